// ----- rtl/wsgt_pkg.sv -----
// Package for the weighted sampler with guide table.
// Holds sizing constants, opcodes, status codes, scan index and write address codes and the shared struct types.
// No dependencies.
package wsgt_pkg;

   // sizing
   localparam int CAPACITY    = 1024;
   localparam int GUIDE_SIZE  = 128;
   localparam int WEIGHT_BITS = 16;

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int SUM_W  = WEIGHT_BITS + IDX_W;
   localparam int GIDX_W = $clog2(GUIDE_SIZE);
   localparam int JT_W   = SUM_W + GIDX_W + 1;
   localparam int WIN_W  = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;

   // opcodes
   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_SAMPLE = 2'd2;
   localparam logic [1:0] OP_NOP    = 2'd3;

   // status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_ZERO_WEIGHT = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND   = 3'd2;
   localparam logic [2:0] ST_EMPTY       = 3'd3;
   localparam logic [2:0] ST_FULL        = 3'd4;

   // scan index operations
   localparam logic [2:0] IDX_HOLD  = 3'd0;
   localparam logic [2:0] IDX_CLR   = 3'd1;
   localparam logic [2:0] IDX_INC   = 3'd2;
   localparam logic [2:0] IDX_GUIDE = 3'd3;
   localparam logic [2:0] IDX_LAST  = 3'd4;

   // element write address select
   localparam logic [1:0] WA_IDX   = 2'd0;
   localparam logic [1:0] WA_IDXM1 = 2'd1;
   localparam logic [1:0] WA_CNT   = 2'd2;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [31:0] key;
      logic [15:0]        weight;
      logic [31:0]        uniform_fraction;
   } req_type;

   typedef struct packed {
      logic signed [31:0] picked_key;
      logic [2:0]         status;
      logic [10:0]        element_count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       load_req;
      logic [2:0] idx_op;
      logic       n_inc;
      logic       n_dec;
      logic       acc_clr;
      logic       acc_add;
      logic       total_load;
      logic       guide_clr;
      logic       guide_wr;
      logic       samp_mul;
      logic       elem_we;
      logic [1:0] wa_sel;
      logic       wd_from_ram;
      logic       res_load;
      logic [2:0] res_status;
      logic       res_key_load;
      logic       out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] op;
      logic       idx_lt_n;
      logic       key_match;
      logic       n_full;
      logic       n_zero;
      logic       weight_zero;
      logic       guide_adv;
      logic       samp_adv;
      logic       j_last;
      logic       out_free;
   } stat_type;

endpackage

// ----- rtl/weighted_sampler_guide_table_unit.sv -----
// Top level of the weighted sampler with guide table.
// Depends on wsgt_pkg, wsgt_ctrl and wsgt_dp.
//
// Usage:
// - Request channel (req_valid/req_stall/req_payload) carries add/update, remove or
//   sample requests; one response per request on rsp_valid/rsp_stall/rsp_payload.
// - One request at a time: req_stall is high from acceptance until the response
//   has been placed in the output register. The next request is taken while
//   that response still waits for the receiver.
// - Work per request:
//     zero weight, empty table, unused opcode: response only
//     add/update/remove: key search (plus shift on remove), running sums,
//       guide build over all GUIDE_SIZE entries
//     sample: multiply, guide lookup, scan from the guide entry
//   Every table step is one read of a registered-read memory.
// - Reset empties the table (count and total cleared); memory contents are
//   not cleared and are never read before they are written.
// - A stalled response holds in the output register; once the block has
//   finished the following request it waits until the register is free.
module weighted_sampler_guide_table_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  wsgt_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output wsgt_pkg::rsp_type rsp_payload
);
   import wsgt_pkg::*;

   cmd_type  cmd;
   stat_type st;

   wsgt_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .st(st), .cmd(cmd));

   wsgt_dp u_dp (
      .clock(clock), .reset(reset), .req_payload(req_payload), .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid), .rsp_payload(rsp_payload), .cmd(cmd), .st(st));
endmodule

// ----- rtl/wsgt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wsgt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- rtl/wsgt_dp.sv -----
// Datapath: element, sum and guide memories, scan counters, sampler multiply, result register.
// Depends on wsgt_pkg and wsgt_ram.
module wsgt_dp (
   input  logic              clock,
   input  logic              reset,
   input  wsgt_pkg::req_type req_payload,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output wsgt_pkg::rsp_type rsp_payload,
   input  wsgt_pkg::cmd_type cmd,
   output wsgt_pkg::stat_type st
);
   import wsgt_pkg::*;

   req_type             req_ff;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    n_ff;
   logic [SUM_W-1:0]    acc_ff, total_ff, target_ff;
   logic [GIDX_W-1:0]   j_ff, gidx_ff;
   logic [JT_W-1:0]     jt_ff;
   logic [2:0]          res_status_ff;
   logic [31:0]         res_key_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;

   logic [31:0]            key_rdata, key_wdata;
   logic [WEIGHT_BITS-1:0] wt_rdata, wt_wdata, w_in;
   logic [SUM_W-1:0]       sum_rdata, acc_sum;
   logic [CNT_W-1:0]       guide_rdata;
   logic [CNT_W-1:0]       idx_m1;
   logic [IDX_W-1:0]       waddr;
   logic [31+SUM_W:0]      t_prod;
   logic [32+GIDX_W:0]     g_prod;

   // request weight, low WEIGHT_BITS bits of the field
   assign w_in    = WEIGHT_BITS'(req_ff.weight[WIN_W-1:0]);
   assign idx_m1  = idx_ff - CNT_W'(1);
   assign acc_sum = acc_ff + SUM_W'(wt_rdata);

   // element write address and data
   always_comb begin
      case (cmd.wa_sel)
         WA_IDXM1: waddr = idx_m1[IDX_W-1:0];
         WA_CNT:   waddr = n_ff[IDX_W-1:0];
         default:  waddr = idx_ff[IDX_W-1:0];
      endcase
   end
   assign key_wdata = cmd.wd_from_ram ? key_rdata : 32'(req_ff.key);
   assign wt_wdata  = cmd.wd_from_ram ? wt_rdata : w_in;

   wsgt_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_keys (
      .clock(clock), .we(cmd.elem_we), .waddr(waddr), .wdata(key_wdata),
      .raddr(idx_ff[IDX_W-1:0]), .rdata(key_rdata));

   wsgt_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(CAPACITY)) u_weights (
      .clock(clock), .we(cmd.elem_we), .waddr(waddr), .wdata(wt_wdata),
      .raddr(idx_ff[IDX_W-1:0]), .rdata(wt_rdata));

   wsgt_ram #(.WIDTH(SUM_W), .DEPTH(CAPACITY)) u_sums (
      .clock(clock), .we(cmd.acc_add), .waddr(idx_ff[IDX_W-1:0]), .wdata(acc_sum),
      .raddr(idx_ff[IDX_W-1:0]), .rdata(sum_rdata));

   wsgt_ram #(.WIDTH(CNT_W), .DEPTH(GUIDE_SIZE)) u_guide (
      .clock(clock), .we(cmd.guide_wr), .waddr(j_ff), .wdata(idx_ff),
      .raddr(gidx_ff), .rdata(guide_rdata));

   // sampler products: target = (u*total)>>32, guide slot = (u*G)>>32
   assign t_prod = (32+SUM_W)'(req_ff.uniform_fraction) * (32+SUM_W)'(total_ff);
   assign g_prod = (33+GIDX_W)'(req_ff.uniform_fraction) * (33+GIDX_W)'(GUIDE_SIZE);

   // scan index
   always_comb begin
      case (cmd.idx_op)
         IDX_CLR:   idx_in = '0;
         IDX_INC:   idx_in = idx_ff + CNT_W'(1);
         IDX_GUIDE: idx_in = guide_rdata;
         IDX_LAST:  idx_in = n_ff - CNT_W'(1);
         default:   idx_in = idx_ff;
      endcase
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) req_ff <= req_payload;
      idx_ff <= idx_in;
      if (cmd.acc_clr) acc_ff <= '0;
      else if (cmd.acc_add) acc_ff <= acc_sum;
      if (cmd.guide_clr) begin
         j_ff  <= '0;
         jt_ff <= '0;
      end else if (cmd.guide_wr) begin
         j_ff  <= j_ff + GIDX_W'(1);
         jt_ff <= jt_ff + JT_W'(total_ff);
      end
      if (cmd.samp_mul) begin
         target_ff <= t_prod[32 +: SUM_W];
         gidx_ff   <= g_prod[32 +: GIDX_W];
      end
      if (cmd.res_load) begin
         res_status_ff <= cmd.res_status;
         res_key_ff    <= '0;
      end else if (cmd.res_key_load) begin
         res_status_ff <= ST_OK;
         res_key_ff    <= key_rdata;
      end
      if (cmd.out_load) begin
         rsp_ff.picked_key    <= res_key_ff;
         rsp_ff.status        <= res_status_ff;
         rsp_ff.element_count <= 11'(n_ff);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff         <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.n_inc) n_ff <= n_ff + CNT_W'(1);
         else if (cmd.n_dec) n_ff <= n_ff - CNT_W'(1);
         if (cmd.total_load) total_ff <= acc_ff;
         if (cmd.out_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // status to controller
   always_comb begin
      st.op          = req_ff.opcode;
      st.idx_lt_n    = idx_ff < n_ff;
      st.key_match   = key_rdata == 32'(req_ff.key);
      st.n_full      = n_ff >= CNT_W'(CAPACITY);
      st.n_zero      = n_ff == '0;
      st.weight_zero = w_in == '0;
      st.guide_adv   = st.idx_lt_n &&
                       (JT_W'(sum_rdata) * JT_W'(GUIDE_SIZE) <= jt_ff);
      st.samp_adv    = st.idx_lt_n && (sum_rdata <= target_ff);
      st.j_last      = j_ff == GIDX_W'(GUIDE_SIZE - 1);
      st.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
endmodule

// ----- rtl/wsgt_ctrl.sv -----
// Controller state machine: sequences key search, shift, rebuild, guide build and sampling.
// Depends on wsgt_pkg.
module wsgt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  wsgt_pkg::stat_type st,
   output wsgt_pkg::cmd_type  cmd
);
   import wsgt_pkg::*;

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_DISP   = 5'd1;
   localparam logic [4:0] S_FD_RD  = 5'd2;
   localparam logic [4:0] S_FD_CMP = 5'd3;
   localparam logic [4:0] S_SH_RD  = 5'd4;
   localparam logic [4:0] S_SH_WR  = 5'd5;
   localparam logic [4:0] S_RB_RD  = 5'd6;
   localparam logic [4:0] S_RB_ACC = 5'd7;
   localparam logic [4:0] S_G_RD   = 5'd8;
   localparam logic [4:0] S_G_CMP  = 5'd9;
   localparam logic [4:0] S_SM_MUL = 5'd10;
   localparam logic [4:0] S_SM_GRD = 5'd11;
   localparam logic [4:0] S_SM_GLD = 5'd12;
   localparam logic [4:0] S_SM_RD  = 5'd13;
   localparam logic [4:0] S_SM_CMP = 5'd14;
   localparam logic [4:0] S_SM_KRD = 5'd15;
   localparam logic [4:0] S_SM_KEY = 5'd16;
   localparam logic [4:0] S_OUT    = 5'd17;

   logic [4:0] state_ff, state_in;

   assign req_stall = state_ff != S_IDLE;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               cmd.idx_op   = IDX_CLR;
               state_in     = S_DISP;
            end
         end
         S_DISP: begin
            case (st.op)
               OP_ADD: begin
                  if (st.weight_zero) begin
                     cmd.res_load   = 1'b1;
                     cmd.res_status = ST_ZERO_WEIGHT;
                     state_in       = S_OUT;
                  end else begin
                     state_in = S_FD_RD;
                  end
               end
               OP_REMOVE: state_in = S_FD_RD;
               OP_SAMPLE: begin
                  if (st.n_zero) begin
                     cmd.res_load   = 1'b1;
                     cmd.res_status = ST_EMPTY;
                     state_in       = S_OUT;
                  end else begin
                     state_in = S_SM_MUL;
                  end
               end
               default: begin
                  cmd.res_load   = 1'b1;
                  cmd.res_status = ST_OK;
                  state_in       = S_OUT;
               end
            endcase
         end
         // linear key search, reading then comparing each element
         S_FD_RD: begin
            if (st.idx_lt_n) begin
               state_in = S_FD_CMP;
            end else if (st.op == OP_REMOVE) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_NOT_FOUND;
               state_in       = S_OUT;
            end else if (st.n_full) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_FULL;
               state_in       = S_OUT;
            end else begin
               // append new key
               cmd.elem_we    = 1'b1;
               cmd.wa_sel     = WA_CNT;
               cmd.n_inc      = 1'b1;
               cmd.idx_op     = IDX_CLR;
               cmd.acc_clr    = 1'b1;
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_OK;
               state_in       = S_RB_RD;
            end
         end
         S_FD_CMP: begin
            cmd.idx_op = IDX_INC;
            if (!st.key_match) begin
               state_in = S_FD_RD;
            end else if (st.op == OP_REMOVE) begin
               state_in = S_SH_RD;
            end else begin
               // update in place
               cmd.elem_we    = 1'b1;
               cmd.wa_sel     = WA_IDX;
               cmd.idx_op     = IDX_CLR;
               cmd.acc_clr    = 1'b1;
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_OK;
               state_in       = S_RB_RD;
            end
         end
         // close the gap: move element idx down to idx-1
         S_SH_RD: begin
            if (st.idx_lt_n) begin
               state_in = S_SH_WR;
            end else begin
               cmd.n_dec      = 1'b1;
               cmd.idx_op     = IDX_CLR;
               cmd.acc_clr    = 1'b1;
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_OK;
               state_in       = S_RB_RD;
            end
         end
         S_SH_WR: begin
            cmd.elem_we     = 1'b1;
            cmd.wa_sel      = WA_IDXM1;
            cmd.wd_from_ram = 1'b1;
            cmd.idx_op      = IDX_INC;
            state_in        = S_SH_RD;
         end
         // running sums
         S_RB_RD: begin
            if (st.idx_lt_n) begin
               state_in = S_RB_ACC;
            end else begin
               cmd.total_load = 1'b1;
               if (st.n_zero) begin
                  state_in = S_OUT;
               end else begin
                  cmd.idx_op    = IDX_CLR;
                  cmd.guide_clr = 1'b1;
                  state_in      = S_G_RD;
               end
            end
         end
         S_RB_ACC: begin
            cmd.acc_add = 1'b1;
            cmd.idx_op  = IDX_INC;
            state_in    = S_RB_RD;
         end
         // guide table: advance index or emit one entry
         S_G_RD: state_in = S_G_CMP;
         S_G_CMP: begin
            if (st.guide_adv) begin
               cmd.idx_op = IDX_INC;
               state_in   = S_G_RD;
            end else begin
               cmd.guide_wr = 1'b1;
               if (st.j_last) state_in = S_OUT;
            end
         end
         // sampling
         S_SM_MUL: begin
            cmd.samp_mul = 1'b1;
            state_in     = S_SM_GRD;
         end
         S_SM_GRD: state_in = S_SM_GLD;
         S_SM_GLD: begin
            cmd.idx_op = IDX_GUIDE;
            state_in   = S_SM_RD;
         end
         S_SM_RD: state_in = S_SM_CMP;
         S_SM_CMP: begin
            if (st.samp_adv) begin
               cmd.idx_op = IDX_INC;
               state_in   = S_SM_RD;
            end else begin
               if (!st.idx_lt_n) cmd.idx_op = IDX_LAST;
               state_in = S_SM_KRD;
            end
         end
         S_SM_KRD: state_in = S_SM_KEY;
         S_SM_KEY: begin
            cmd.res_key_load = 1'b1;
            state_in         = S_OUT;
         end
         S_OUT: begin
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule

// ----- rtl/wsgt_checker.sv -----
// Port-level checks for the weighted sampler, bound to the top level.
// Depends on wsgt_pkg.
module wsgt_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input wsgt_pkg::rsp_type rsp_payload
);
   import wsgt_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // one request at a time
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while busy");

   // failed requests return a zero key
   a_zero_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status != ST_OK) |-> rsp_payload.picked_key == '0)
      else $error("nonzero key on error status");

   // count stays in range
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.element_count <= 11'(CAPACITY))
      else $error("element count out of range");

   // nothing pending after reset
   a_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");
endmodule

bind weighted_sampler_guide_table_unit wsgt_checker u_wsgt_checker (.*);

// ----- test/tb_weighted_sampler_guide_table_unit.sv -----
// Testbench for weighted_sampler_guide_table_unit: drives add, remove, sample and unused-opcode requests
// and checks every response against a predictor of the keyed weight table.
// Depends on wsgt_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_weighted_sampler_guide_table_unit;
   import wsgt_pkg::*;

   // Weight table predictor together with the queue of expected responses.
   class sampler_scoreboard;
      logic [31:0] keys [CAPACITY];
      logic [15:0] weights [CAPACITY];
      logic [25:0] sums [CAPACITY];
      int          guide [GUIDE_SIZE];
      int          count;
      logic [25:0] total;
      rsp_type     expected_q [$];
      int          errors;

      function void clear();
         count = 0;
         total = '0;
         errors = 0;
         expected_q.delete();
      endfunction

      // Cumulative sums and guide entries after every change.
      function void rebuild();
         logic [63:0] acc;
         logic [63:0] thr;
         int i;
         acc = '0;
         for (i = 0; i < count; i++) begin
            acc += weights[i];
            sums[i] = acc[25:0];
         end
         total = acc[25:0];
         if (count == 0) return;
         i = 0;
         for (int j = 0; j < GUIDE_SIZE; j++) begin
            thr = (64'(j) * 64'(total)) / GUIDE_SIZE;
            while (i < count && 64'(sums[i]) <= thr) i++;
            guide[j] = i;
         end
      endfunction

      function int find(logic [31:0] k);
         for (int i = 0; i < count; i++)
            if (keys[i] == k) return i;
         return -1;
      endfunction

      // Note an accepted request and queue the response it must produce.
      function void note_request(req_type r);
         rsp_type     e;
         int          pos;
         int          i;
         logic [63:0] target;
         e = '0;
         e.status = ST_OK;
         case (r.opcode)
            OP_ADD: begin
               if (r.weight == 0) e.status = ST_ZERO_WEIGHT;
               else begin
                  pos = find(r.key);
                  if (pos >= 0) begin
                     weights[pos] = r.weight;
                     rebuild();
                  end else if (count >= CAPACITY) e.status = ST_FULL;
                  else begin
                     keys[count] = r.key;
                     weights[count] = r.weight;
                     count++;
                     rebuild();
                  end
               end
            end
            OP_REMOVE: begin
               pos = find(r.key);
               if (pos < 0) e.status = ST_NOT_FOUND;
               else begin
                  for (i = pos; i + 1 < count; i++) begin
                     keys[i] = keys[i + 1];
                     weights[i] = weights[i + 1];
                  end
                  count--;
                  rebuild();
               end
            end
            OP_SAMPLE: begin
               if (count == 0) e.status = ST_EMPTY;
               else begin
                  target = (64'(r.uniform_fraction) * 64'(total)) >> 32;
                  i = guide[r.uniform_fraction[31:25]];
                  while (i < count && 64'(sums[i]) <= target) i++;
                  if (i >= count) i = count - 1;
                  e.picked_key = keys[i];
               end
            end
            default: ;
         endcase
         e.element_count = 11'(count);
         expected_q.push_back(e);
      endfunction

      // Compare one response with the oldest expectation.
      function void check_response(rsp_type a);
         rsp_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response key=%0d status=%0d count=%0d",
                     $time, a.picked_key, a.status, a.element_count);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (a.picked_key !== e.picked_key) begin
            $display("%0t: picked_key expected %0d actual %0d",
                     $time, e.picked_key, a.picked_key);
            errors++;
         end
         if (a.status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
            errors++;
         end
         if (a.element_count !== e.element_count) begin
            $display("%0t: element_count expected %0d actual %0d",
                     $time, e.element_count, a.element_count);
            errors++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   sampler_scoreboard table_sb = new();
   logic [31:0]       key_pool [20];
   bit                burst_mode;
   int                stall_left;
   longint            cycle_count;

   weighted_sampler_guide_table_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Mostly short gaps, a few long ones, none in burst stretches.
   function automatic int gap_length();
      int p;
      p = $urandom_range(0, 99);
      if (burst_mode || p < 50) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Response side: random stall, check on every accepted response.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) table_sb.check_response(rsp_payload);
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            stall_left <= gap_length();
            rsp_stall <= 1'b0;
         end
      end
   end

   // Cycle limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 40_000_000) begin
         $display("FAIL weighted_sampler_guide_table_unit");
         $finish;
      end
   end

   // Present one request and hold it until accepted; valid stays high.
   task automatic send_request(req_type r);
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      table_sb.note_request(r);
   endtask

   task automatic send_gapped(req_type r);
      int g;
      g = gap_length();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      send_request(r);
   endtask

   function automatic req_type make_req(logic [1:0] op, logic [31:0] k,
                                        logic [15:0] w, logic [31:0] u);
      req_type r;
      r.opcode = op;
      r.key = k;
      r.weight = w;
      r.uniform_fraction = u;
      return r;
   endfunction

   function automatic req_type random_req();
      int p;
      logic [15:0] w;
      p = $urandom_range(0, 99);
      w = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom);
      if ($urandom_range(0, 2) == 0) w = 16'($urandom_range(1, 8));
      if ($urandom_range(0, 29) == 0) w = '0;
      if (p < 45)
         return make_req(OP_ADD, key_pool[$urandom_range(0, 19)], w, $urandom);
      if (p < 60)
         return make_req(OP_REMOVE, ($urandom_range(0, 9) == 0) ? $urandom
                         : key_pool[$urandom_range(0, 19)], w, $urandom);
      if (p < 95)
         return make_req(OP_SAMPLE, $urandom, w, $urandom);
      return make_req(OP_NOP, $urandom, 16'($urandom), $urandom);
   endfunction

   initial begin
      cycle_count = 0;
      stall_left = 0;
      burst_mode = 1'b0;
      table_sb.clear();
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hFFFF_FFFF;
      for (int i = 4; i < 20; i++) key_pool[i] = $urandom;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: error statuses, extremes, update in place, removal order.
      send_gapped(make_req(OP_SAMPLE, 32'h0, 16'h0, 32'hFFFF_FFFF));
      send_gapped(make_req(OP_ADD, 32'h1234, 16'h0, 32'h0));
      send_gapped(make_req(OP_REMOVE, 32'h1234, 16'h1, 32'h0));
      send_gapped(make_req(OP_NOP, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
      send_gapped(make_req(OP_ADD, 32'h8000_0000, 16'hFFFF, 32'h0));
      send_gapped(make_req(OP_SAMPLE, 32'h0, 16'h0, 32'h0));
      send_gapped(make_req(OP_SAMPLE, 32'h0, 16'h0, 32'hFFFF_FFFF));
      send_gapped(make_req(OP_ADD, 32'h7FFF_FFFF, 16'h0001, 32'h0));
      send_gapped(make_req(OP_ADD, 32'h0, 16'h0001, 32'h0));
      send_gapped(make_req(OP_ADD, 32'hFFFF_FFFF, 16'h8000, 32'h0));
      send_gapped(make_req(OP_SAMPLE, 32'h0, 16'h0, 32'h0));
      send_gapped(make_req(OP_SAMPLE, 32'h0, 16'h0, 32'hFFFF_FFFF));
      send_gapped(make_req(OP_SAMPLE, 32'h0, 16'h0, 32'hFFFF_0000));
      send_gapped(make_req(OP_SAMPLE, 32'h0, 16'h0, 32'hFFFE_FFFF));
      send_gapped(make_req(OP_ADD, 32'h8000_0000, 16'h0001, 32'h0));
      send_gapped(make_req(OP_SAMPLE, 32'h0, 16'h0, 32'h0));
      send_gapped(make_req(OP_REMOVE, 32'h7FFF_FFFF, 16'h0, 32'h0));
      send_gapped(make_req(OP_SAMPLE, 32'h0, 16'h0, 32'h8000_0000));
      send_gapped(make_req(OP_REMOVE, 32'h8000_0000, 16'h0, 32'h0));
      send_gapped(make_req(OP_REMOVE, 32'hFFFF_FFFF, 16'h0, 32'h0));
      send_gapped(make_req(OP_REMOVE, 32'h0, 16'h0, 32'h0));
      send_gapped(make_req(OP_SAMPLE, 32'h0, 16'h0, 32'h4000_0000));

      // Random traffic over a small key pool, with one full drain midway.
      for (int n = 0; n < 500; n++) begin
         if (n % 60 == 0) burst_mode = ($urandom_range(0, 2) == 0);
         if (n == 250) begin
            req_valid <= 1'b0;
            while (table_sb.expected_q.size() != 0) @(posedge clock);
         end
         send_gapped(random_req());
      end

      // Closing samples over the final table.
      for (int i = 0; i < 6; i++)
         send_gapped(make_req(OP_SAMPLE, 32'h0, 16'h0, $urandom));
      send_gapped(make_req(OP_SAMPLE, 32'h0, 16'h0, 32'hFFFF_FFFF));
      req_valid <= 1'b0;

      while (table_sb.expected_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (table_sb.errors == 0)
         $display("PASS weighted_sampler_guide_table_unit");
      else
         $display("FAIL weighted_sampler_guide_table_unit");
      $finish;
   end
endmodule

// ----- filelist.f -----
rtl/wsgt_pkg.sv
rtl/wsgt_ram.sv
rtl/wsgt_dp.sv
rtl/wsgt_ctrl.sv
rtl/weighted_sampler_guide_table_unit.sv
rtl/wsgt_checker.sv
test/tb_weighted_sampler_guide_table_unit.sv
